// ===== rtl/mjd_bcd_time_to_calendar_top_macros.svh =====
// Assertion helpers, clocked on clk and disabled while arst_n is low.
`ifndef MJD_BCD_TIME_TO_CALENDAR_TOP_MACROS_SVH
`define MJD_BCD_TIME_TO_CALENDAR_TOP_MACROS_SVH

// Same-cycle implication.
`define MBTC_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define MBTC_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/mbtc_pkg.sv =====
package mbtc_pkg;

	// Depth of the queue between front and back.
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);

	localparam int unsigned U_W = 19;

	// MJD at which the Gregorian correction term b steps from 49 to 50.
	localparam logic [15:0] GREG_SPLIT_MJD = 16'd15079;
	// 4*jd - 237 reduced modulo 1461, with the MJD term taken out.
	localparam logic [U_W-1:0] U_BASE = 19'd1045;
	localparam logic [10:0] DAYS_4Y = 11'd1461;
	// floor(2^30 / 1461); the estimate is low by at most one.
	localparam logic [19:0] RECIP_4Y = 20'd734936;
	localparam int unsigned RECIP_SHIFT = 30;
	localparam logic [8:0] YEAR_BIAS = 9'd42;
	// Remainder at which the quarter-day offset rolls the year over.
	localparam logic [10:0] YEAR_ROLL = 11'd1224;
	localparam logic [3:0] MONTHS_FROM_MARCH = 4'd12;
	localparam logic [3:0] MONTH_WRAP = 4'd10;

	typedef struct packed {
		logic [U_W-1:0] u;
		logic [6:0]     hour;
		logic [6:0]     minute;
		logic [6:0]     second;
	} item_t;

	// First day index (days since March 1) of each month counted from March.
	function automatic logic [8:0] month_first_day(input logic [3:0] mi);
		logic [8:0] t;
		begin
			case (mi)
				4'd0:    t = 9'd0;
				4'd1:    t = 9'd31;
				4'd2:    t = 9'd61;
				4'd3:    t = 9'd92;
				4'd4:    t = 9'd122;
				4'd5:    t = 9'd153;
				4'd6:    t = 9'd184;
				4'd7:    t = 9'd214;
				4'd8:    t = 9'd245;
				4'd9:    t = 9'd275;
				4'd10:   t = 9'd306;
				4'd11:   t = 9'd337;
				default: t = 9'd0;
			endcase
			return t;
		end
	endfunction

endpackage

// ===== rtl/mbtc_front.sv =====
module mbtc_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic [39:0]          time_code,
	output logic                 q_push,
	input  logic                 q_full,
	output mbtc_pkg::item_t      q_item
);

	logic            vld_s1;
	mbtc_pkg::item_t item_s1;
	mbtc_pkg::item_t item_d;
	logic            accept;
	logic [15:0]     mjd;
	logic            greg;

	function automatic logic [6:0] bcd_decode(input logic [7:0] b);
		logic [3:0] hi;
		logic [3:0] lo;
		logic [6:0] v;
		begin
			hi = b[7:4];
			lo = b[3:0];
			if (hi > 4'd9)
				v = 7'd0;
			else if (lo > 4'd9)
				v = 7'(hi);
			else
				v = 7'(7'(hi) * 7'd10 + 7'(lo));
			return v;
		end
	endfunction

	assign full   = vld_s1 && q_full;
	assign accept = push && !full;
	assign q_push = vld_s1 && !q_full;
	assign q_item = item_s1;

	assign mjd  = time_code[39:24];
	assign greg = (mjd >= mbtc_pkg::GREG_SPLIT_MJD);

	always_comb begin
		item_d.u      = {1'b0, mjd, 2'b00} + mbtc_pkg::U_BASE + {16'd0, greg, 2'b00};
		item_d.hour   = bcd_decode(time_code[23:16]);
		item_d.minute = bcd_decode(time_code[15:8]);
		item_d.second = bcd_decode(time_code[7:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (q_push) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_d;
		end
	end

endmodule

// ===== rtl/mbtc_fifo.sv =====
`include "mjd_bcd_time_to_calendar_top_macros.svh"

module mbtc_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  mbtc_pkg::item_t wr_data,
	output logic            full,
	input  logic            rd_en,
	output mbtc_pkg::item_t rd_data,
	output logic            empty
);

	mbtc_pkg::item_t                  mem_q [mbtc_pkg::QDEPTH];
	logic [mbtc_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [mbtc_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [mbtc_pkg::QPTR_W:0]        cnt_q;
	logic                             do_wr;
	logic                             do_rd;

	assign full    = (cnt_q == (mbtc_pkg::QPTR_W+1)'(mbtc_pkg::QDEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_rd)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	`MBTC_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_q <= (mbtc_pkg::QPTR_W+1)'(mbtc_pkg::QDEPTH), "queue count overflow")
	`MBTC_ASSERT_NEXT(a_wr_counts, do_wr && !do_rd, cnt_q == $past(cnt_q) + 1'b1, "write not counted")

endmodule

// ===== rtl/mbtc_back.sv =====
`include "mjd_bcd_time_to_calendar_top_macros.svh"

module mbtc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	input  mbtc_pkg::item_t     q_item,
	output logic                q_pop,
	output logic                empty,
	input  logic                pop,
	output logic signed [8:0]   year_since_1900,
	output logic [3:0]          month,
	output logic [4:0]          day,
	output logic [6:0]          hour,
	output logic [6:0]          minute,
	output logic [6:0]          second
);

	// stage 1: quotient estimate of u / 1461
	logic                         vld_s1;
	logic [mbtc_pkg::U_W-1:0]     u_s1;
	logic [7:0]                   qe_s1;
	logic [6:0]                   hr_s1, mn_s1, sc_s1;
	// stage 2: exact quotient and remainder
	logic                         vld_s2;
	logic [7:0]                   q_s2;
	logic [10:0]                  r_s2;
	logic [6:0]                   hr_s2, mn_s2, sc_s2;
	// stage 3: result register
	logic                         vld_s3;
	logic signed [8:0]            yr_s3;
	logic [3:0]                   mon_s3;
	logic [4:0]                   day_s3;
	logic [6:0]                   hr_s3, mn_s3, sc_s3;

	logic                         adv1, adv2, adv3;
	logic [38:0]                  prod;
	logic [mbtc_pkg::U_W-1:0]     qm;
	logic [11:0]                  rr;
	logic [7:0]                   q_fix;
	logic [10:0]                  r_fix;
	logic [8:0]                   doy;
	logic [3:0]                   mi;
	logic [3:0]                   mon_d;
	logic [4:0]                   day_d;
	logic [8:0]                   yr_d;

	assign adv3  = !vld_s3 || pop;
	assign adv2  = !vld_s2 || adv3;
	assign adv1  = !vld_s1 || adv2;
	assign q_pop = !q_empty && adv1;
	assign empty = !vld_s3;

	assign prod = 39'(q_item.u) * 39'(mbtc_pkg::RECIP_4Y);

	always_comb begin
		qm = mbtc_pkg::U_W'(mbtc_pkg::U_W'(qe_s1) * mbtc_pkg::U_W'(mbtc_pkg::DAYS_4Y));
		rr = 12'(u_s1 - qm);
		if (rr >= 12'(mbtc_pkg::DAYS_4Y)) begin
			r_fix = 11'(rr - 12'(mbtc_pkg::DAYS_4Y));
			q_fix = qe_s1 + 8'd1;
		end else begin
			r_fix = rr[10:0];
			q_fix = qe_s1;
		end
	end

	// month index counted from March, then day within month, calendar month and year
	always_comb begin
		doy = r_s2[10:2];
		mi  = 4'd0;
		for (int k = 1; k < 12; k++) begin
			if (doy >= mbtc_pkg::month_first_day(4'(k)))
				mi = mi + 4'd1;
		end
		day_d = 5'(doy - mbtc_pkg::month_first_day(mi) + 9'd1);
		if (mi >= mbtc_pkg::MONTH_WRAP)
			mon_d = mi - mbtc_pkg::MONTH_WRAP;
		else
			mon_d = mi + (mbtc_pkg::MONTHS_FROM_MARCH - mbtc_pkg::MONTH_WRAP);
		yr_d = 9'(q_s2) - mbtc_pkg::YEAR_BIAS + 9'(r_s2 >= mbtc_pkg::YEAR_ROLL);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (adv1)
				vld_s1 <= q_pop;
			if (adv2)
				vld_s2 <= vld_s1;
			if (adv3)
				vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			u_s1  <= q_item.u;
			qe_s1 <= prod[mbtc_pkg::RECIP_SHIFT+7:mbtc_pkg::RECIP_SHIFT];
			hr_s1 <= q_item.hour;
			mn_s1 <= q_item.minute;
			sc_s1 <= q_item.second;
		end
		if (adv2) begin
			q_s2  <= q_fix;
			r_s2  <= r_fix;
			hr_s2 <= hr_s1;
			mn_s2 <= mn_s1;
			sc_s2 <= sc_s1;
		end
		if (adv3) begin
			yr_s3  <= $signed(yr_d);
			mon_s3 <= mon_d;
			day_s3 <= day_d;
			hr_s3  <= hr_s2;
			mn_s3  <= mn_s2;
			sc_s3  <= sc_s2;
		end
	end

	assign year_since_1900 = yr_s3;
	assign month           = mon_s3;
	assign day             = day_s3;
	assign hour            = hr_s3;
	assign minute          = mn_s3;
	assign second          = sc_s3;

	`MBTC_ASSERT_IMPL(a_rem_range, vld_s2, r_s2 < mbtc_pkg::DAYS_4Y, "remainder not reduced")
	`MBTC_ASSERT_IMPL(a_month_range, vld_s3, mon_s3 < mbtc_pkg::MONTHS_FROM_MARCH, "month out of range")
	`MBTC_ASSERT_NEXT(a_hold_stall, vld_s3 && !pop, vld_s3 && $stable(yr_s3) && $stable(day_s3),
		"result changed while stalled")

endmodule

// ===== rtl/mjd_bcd_time_to_calendar_top.sv =====
// MJD + BCD time code to calendar date and time of day.
// Input channel: push / full with a 40-bit time_code (MJD in bits 39..24,
// BCD hour, minute, second below). A request is taken on a rising edge with
// push high and full low.
// Result channel: empty / pop. While empty is low the oldest result is on
// year_since_1900, month, day, hour, minute, second; it is taken on an edge
// with pop high.
// Throughput: one request per cycle, with no gaps, while pop keeps up.
// Path: when the result side is not stalled, a request passes the input register,
// the queue write and the three back stages before empty falls.
// The date divide by 1461 is a reciprocal multiply and one correction step,
// split over two back stages; month and day come from a compare table.
// Stalls: when pop stays low the back stages fill, then the four-entry queue,
// then the input register, and only then full rises.
// Reset (arst_n low): all queues and stages empty, full and empty low/high.
module mjd_bcd_time_to_calendar_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [39:0]       time_code,
	output logic              empty,
	input  logic              pop,
	output logic signed [8:0] year_since_1900,
	output logic [3:0]        month,
	output logic [4:0]        day,
	output logic [6:0]        hour,
	output logic [6:0]        minute,
	output logic [6:0]        second
);

	logic            q_push;
	logic            q_full;
	logic            q_pop;
	logic            q_empty;
	mbtc_pkg::item_t q_wr_item;
	mbtc_pkg::item_t q_rd_item;

	mbtc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.time_code (time_code),
		.q_push    (q_push),
		.q_full    (q_full),
		.q_item    (q_wr_item)
	);

	mbtc_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (q_wr_item),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_data (q_rd_item),
		.empty   (q_empty)
	);

	mbtc_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_empty         (q_empty),
		.q_item          (q_rd_item),
		.q_pop           (q_pop),
		.empty           (empty),
		.pop             (pop),
		.year_since_1900 (year_since_1900),
		.month           (month),
		.day             (day),
		.hour            (hour),
		.minute          (minute),
		.second          (second)
	);

endmodule
